>>> hw/rtl/i2cm16_pkg.sv
package i2cm16_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned RADDR_W = 16;

  localparam logic [BYTE_W-1:0] ACK_TIMEOUT_RST = 8'd250;

  // One result item
  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              wr_data_taken;
    logic [BYTE_W-1:0] rd_data;
    logic              rd_valid;
    logic              done_res;
    logic              nack_error;
  } out_pay_t;

endpackage

>>> hw/rtl/i2cm16_in_if.sv
interface i2cm16_in_if import i2cm16_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [BYTE_W-1:0]  dev_addr;
  logic [RADDR_W-1:0] reg_addr;
  logic [BYTE_W-1:0]  byte_count;
  logic [BYTE_W-1:0]  wr_data;
  logic               sda_in;

  modport source (output valid, req_type, dev_addr, reg_addr, byte_count, wr_data, sda_in,
                  input ready);
  modport sink (input valid, req_type, dev_addr, reg_addr, byte_count, wr_data, sda_in,
                output ready);
endinterface

>>> hw/rtl/i2cm16_out_if.sv
interface i2cm16_out_if import i2cm16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_out;
  logic              sda_out;
  logic              busy_res;
  logic              wr_data_taken;
  logic [BYTE_W-1:0] rd_data;
  logic              rd_valid;
  logic              done_res;
  logic              nack_error;

  modport source (output valid, scl_out, sda_out, busy_res, wr_data_taken, rd_data,
                  rd_valid, done_res, nack_error, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, wr_data_taken, rd_data,
                rd_valid, done_res, nack_error, output ready);
endinterface

>>> hw/rtl/i2cm16_cfg_if.sv
interface i2cm16_cfg_if import i2cm16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] ack_timeout;

  modport source (output valid, ack_timeout, input ready);
  modport sink (input valid, ack_timeout, output ready);
endinterface

>>> hw/rtl/i2c_master_reg16_bitbang.sv
// I2C master for devices with a 16-bit register address, bit-banged one pin
// step per request.
// in_ch: one request per bus delay tick. It carries the sampled SDA level and,
//   while the block is idle, may start a write (req_type 1) or a read
//   (req_type 2) using dev_addr, reg_addr and byte_count. wr_data is sampled
//   on the tick whose result shows wr_data_taken.
// out_ch: exactly one result per request: SCL/SDA drive levels for that tick,
//   busy, read byte strobe, done and nack_error.
// cfg_ch: writes ack_timeout (reset 250); always ready, write only when idle.
// Latency: the result of a request is valid on out_ch the cycle after it is
//   accepted unless an older result still waits. Throughput: one request per
//   cycle while in_ch.ready is high; the pin sequencer takes a single step per
//   request, computed in combinational logic.
// Stalls: results go to an output register backed by one skid register, so a
//   request is still taken while one result waits; in_ch.ready drops only
//   once both hold a result, and resumes the cycle after out_ch drains one.
// Reset (rst_n low, synchronous): sequencer idle, both lines released,
//   output and skid registers empty.
module i2c_master_reg16_bitbang import i2cm16_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  i2cm16_in_if.sink    in_ch,
  i2cm16_out_if.source out_ch,
  i2cm16_cfg_if.sink   cfg_ch
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LO, PH_TX_HI, PH_ACK_REL, PH_ACK_HI,
    PH_ACK_LO, PH_RX_HI, PH_RX_LO, PH_MA_LO, PH_MA_HI, PH_MA_END, PH_MA_REL,
    PH_SP_A, PH_SP_B, PH_SP_C
  } phase_t;

  // Which byte is on the wire
  typedef enum logic [2:0] {
    STG_DEV, STG_AHI, STG_ALO, STG_DATA, STG_RDEV
  } stage_t;

  phase_t              phase_r, phase_nxt;
  stage_t              stage_r, stage_nxt;
  logic [3:0]          bit_idx_r, bit_idx_nxt;
  logic [BYTE_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0]   shift_r, shift_nxt;
  logic [BYTE_W-1:0]   wait_cnt_r, wait_cnt_nxt;
  logic [BYTE_W-1:0]   held_dev_r, held_dev_nxt;
  logic [RADDR_W-1:0]  held_reg_r, held_reg_nxt;
  logic                is_read_r, is_read_nxt;
  logic                failed_r, failed_nxt;
  logic [BYTE_W-1:0]   ack_timeout_r;

  out_pay_t            res;
  out_pay_t            out_pay_r;
  out_pay_t            skid_pay_r;
  logic                out_vld_r;
  logic                skid_vld_r;
  logic                acc;
  logic                out_take;
  logic                ackbit;

  assign in_ch.ready  = !skid_vld_r;
  assign cfg_ch.ready = 1'b1;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_take     = out_vld_r && out_ch.ready;

  // One pin step of the sequencer
  always_comb begin
    phase_nxt      = phase_r;
    stage_nxt      = stage_r;
    bit_idx_nxt    = bit_idx_r;
    bytes_left_nxt = bytes_left_r;
    shift_nxt      = shift_r;
    wait_cnt_nxt   = wait_cnt_r;
    held_dev_nxt   = held_dev_r;
    held_reg_nxt   = held_reg_r;
    is_read_nxt    = is_read_r;
    failed_nxt     = failed_r;
    res            = '0;
    res.scl_out    = 1'b1;
    res.sda_out    = 1'b1;

    // Latch a new transaction; starts while busy are dropped
    if (phase_r == PH_IDLE &&
        (in_ch.req_type == REQ_WRITE || in_ch.req_type == REQ_READ)) begin
      held_dev_nxt   = in_ch.dev_addr;
      held_reg_nxt   = in_ch.reg_addr;
      bytes_left_nxt = in_ch.byte_count;
      is_read_nxt    = (in_ch.req_type == REQ_READ);
      shift_nxt      = in_ch.dev_addr;
      stage_nxt      = STG_DEV;
      bit_idx_nxt    = '0;
      wait_cnt_nxt   = '0;
      failed_nxt     = 1'b0;
      phase_nxt      = PH_ST_A;
    end
    res.busy_res = (phase_nxt != PH_IDLE);
    ackbit       = (bytes_left_nxt == '0);

    unique case (phase_nxt)
      PH_ST_A: begin
        phase_nxt = PH_ST_B;
      end
      PH_ST_B: begin
        res.sda_out = 1'b0;
        phase_nxt   = PH_ST_C;
      end
      PH_ST_C: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b0;
        bit_idx_nxt = '0;
        phase_nxt   = PH_TX_LO;
      end
      PH_TX_LO: begin
        if (stage_nxt == STG_DATA && bit_idx_nxt == '0) begin
          shift_nxt         = in_ch.wr_data;
          res.wr_data_taken = 1'b1;
        end
        res.scl_out = 1'b0;
        res.sda_out = shift_nxt[BYTE_W-1];
        phase_nxt   = PH_TX_HI;
      end
      PH_TX_HI: begin
        res.sda_out = shift_nxt[BYTE_W-1];
        shift_nxt   = {shift_nxt[BYTE_W-2:0], 1'b0};
        bit_idx_nxt = bit_idx_nxt + 4'd1;
        phase_nxt   = (bit_idx_nxt >= 4'd8) ? PH_ACK_REL : PH_TX_LO;
      end
      PH_ACK_REL: begin
        res.scl_out  = 1'b0;
        wait_cnt_nxt = '0;
        phase_nxt    = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        if (!in_ch.sda_in) begin
          phase_nxt = PH_ACK_LO;
        end else if (wait_cnt_nxt >= ack_timeout_r) begin
          // give up on the ACK
          failed_nxt = 1'b1;
          phase_nxt  = PH_ACK_LO;
        end else begin
          wait_cnt_nxt = wait_cnt_nxt + 8'd1;
        end
      end
      PH_ACK_LO: begin
        res.scl_out = 1'b0;
        if (failed_nxt) begin
          phase_nxt = PH_SP_A;
        end else if (stage_nxt == STG_DEV) begin
          shift_nxt   = held_reg_nxt[15:8];
          stage_nxt   = STG_AHI;
          bit_idx_nxt = '0;
          phase_nxt   = PH_TX_LO;
        end else if (stage_nxt == STG_AHI) begin
          shift_nxt   = held_reg_nxt[7:0];
          stage_nxt   = STG_ALO;
          bit_idx_nxt = '0;
          phase_nxt   = PH_TX_LO;
        end else if (stage_nxt == STG_ALO && is_read_nxt) begin
          // repeated START, then device byte in read form
          shift_nxt = held_dev_nxt + 8'd1;
          stage_nxt = STG_RDEV;
          phase_nxt = PH_ST_A;
        end else if (stage_nxt == STG_ALO || stage_nxt == STG_DATA) begin
          if (bytes_left_nxt == '0) begin
            phase_nxt = PH_SP_A;
          end else begin
            bytes_left_nxt = bytes_left_nxt - 8'd1;
            shift_nxt      = '0;
            stage_nxt      = STG_DATA;
            bit_idx_nxt    = '0;
            phase_nxt      = PH_TX_LO;
          end
        end else if (bytes_left_nxt == '0) begin
          phase_nxt = PH_SP_A;
        end else begin
          shift_nxt   = '0;
          bit_idx_nxt = '0;
          phase_nxt   = PH_RX_HI;
        end
      end
      PH_RX_HI: begin
        shift_nxt = {shift_nxt[BYTE_W-2:0], in_ch.sda_in};
        phase_nxt = PH_RX_LO;
      end
      PH_RX_LO: begin
        res.scl_out = 1'b0;
        bit_idx_nxt = bit_idx_nxt + 4'd1;
        if (bit_idx_nxt >= 4'd8) begin
          if (bytes_left_nxt != '0) begin
            bytes_left_nxt = bytes_left_nxt - 8'd1;
          end
          res.rd_data  = shift_nxt;
          res.rd_valid = 1'b1;
          phase_nxt    = PH_MA_LO;
        end else begin
          phase_nxt = PH_RX_HI;
        end
      end
      PH_MA_LO: begin
        res.scl_out = 1'b0;
        res.sda_out = ackbit;
        phase_nxt   = PH_MA_HI;
      end
      PH_MA_HI: begin
        res.sda_out = ackbit;
        phase_nxt   = PH_MA_END;
      end
      PH_MA_END: begin
        res.scl_out = 1'b0;
        res.sda_out = ackbit;
        phase_nxt   = ackbit ? PH_SP_A : PH_MA_REL;
      end
      PH_MA_REL: begin
        res.scl_out = 1'b0;
        shift_nxt   = '0;
        bit_idx_nxt = '0;
        phase_nxt   = PH_RX_HI;
      end
      PH_SP_A: begin
        res.scl_out = 1'b0;
        res.sda_out = 1'b0;
        phase_nxt   = PH_SP_B;
      end
      PH_SP_B: begin
        res.sda_out = 1'b0;
        phase_nxt   = PH_SP_C;
      end
      PH_SP_C: begin
        res.done_res   = 1'b1;
        res.nack_error = failed_nxt;
        phase_nxt      = PH_IDLE;
      end
      default: begin
        // idle: both lines released
        res.busy_res = 1'b0;
        phase_nxt    = PH_IDLE;
      end
    endcase
  end

  // Sequencer state: advance once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      stage_r      <= STG_DEV;
      bit_idx_r    <= '0;
      bytes_left_r <= '0;
      shift_r      <= '0;
      wait_cnt_r   <= '0;
      held_dev_r   <= '0;
      held_reg_r   <= '0;
      is_read_r    <= 1'b0;
      failed_r     <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      stage_r      <= stage_nxt;
      bit_idx_r    <= bit_idx_nxt;
      bytes_left_r <= bytes_left_nxt;
      shift_r      <= shift_nxt;
      wait_cnt_r   <= wait_cnt_nxt;
      held_dev_r   <= held_dev_nxt;
      held_reg_r   <= held_reg_nxt;
      is_read_r    <= is_read_nxt;
      failed_r     <= failed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      ack_timeout_r <= cfg_ch.ack_timeout;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_take) begin
      out_vld_r  <= skid_vld_r || acc;
      skid_vld_r <= 1'b0;
    end else if (acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_take) begin
      out_pay_r <= skid_vld_r ? skid_pay_r : res;
    end
    if (acc && out_vld_r && !out_take) begin
      skid_pay_r <= res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.scl_out       = out_pay_r.scl_out;
  assign out_ch.sda_out       = out_pay_r.sda_out;
  assign out_ch.busy_res      = out_pay_r.busy_res;
  assign out_ch.wr_data_taken = out_pay_r.wr_data_taken;
  assign out_ch.rd_data       = out_pay_r.rd_data;
  assign out_ch.rd_valid      = out_pay_r.rd_valid;
  assign out_ch.done_res      = out_pay_r.done_res;
  assign out_ch.nack_error    = out_pay_r.nack_error;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held without output entry");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pay_r.done_res) |-> out_pay_r.busy_res)
    else $error("done reported outside a transaction");

  a_nack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_pay_r.nack_error) |-> out_pay_r.done_res)
    else $error("nack_error without done");

  a_taken_to_tx_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res.wr_data_taken) |=> (phase_r == PH_TX_HI && stage_r == STG_DATA))
    else $error("write byte taken outside a data bit");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready && acc) |=> skid_vld_r)
    else $error("request accepted during stall was not parked");
`endif

endmodule
